/* hdl/cbms_pkg.sv */
// Shared types, constants and helpers for the complex bin mean/deviation block.
// Used by every RTL file of the block but cbms_ram; depends on nothing.
`default_nettype none

package cbms_pkg;

	// Grid and field geometry.
	localparam int GRID_SIDE = 16;
	localparam int COORD_W   = 4;
	localparam int BIN_COUNT = GRID_SIDE * GRID_SIDE;
	localparam int ADDR_W    = $clog2(BIN_COUNT);
	localparam int SAMPLE_W  = 24;
	localparam int SUM_W     = 32;
	localparam int POWER_W   = 56;
	localparam int SQ_W      = 2 * SAMPLE_W;
	localparam int PWR_IN_W  = SQ_W + 1;
	localparam int ROOT_W    = POWER_W / 2;

	// Divider geometry.
	localparam int DIV_W     = POWER_W;
	localparam int DIV_CNT_W = $clog2(DIV_W);
	localparam int ROOT_CNT_W = $clog2(ROOT_W);

	// Configuration registers.
	localparam int CNT_W      = 8;
	localparam int TOL_W      = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VAR_TOL     = 1'd1;
	localparam logic [CNT_W-1:0] FRAME_COUNT_RST = 8'd60;
	localparam logic [TOL_W-1:0] VAR_TOL_RST     = 16'd42950;

	// Operation codes.
	localparam logic OP_ACCUM = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// One item as it travels from the front end to the back end.
	typedef struct packed {
		logic                       op;
		logic [COORD_W-1:0]         bin_x;
		logic [COORD_W-1:0]         bin_y;
		logic signed [SAMPLE_W-1:0] re;
		logic signed [SAMPLE_W-1:0] im;
		logic [PWR_IN_W-1:0]        pwr;
	} work_t;

	// One entry of the bin store.
	typedef struct packed {
		logic [SUM_W-1:0]   sr;
		logic [SUM_W-1:0]   si;
		logic [POWER_W-1:0] sp;
	} sums_t;

	localparam int ENTRY_W = $bits(sums_t);

	// Status of an iterative unit.
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	// Linear bin address of a coordinate pair.
	function automatic logic [ADDR_W-1:0] bin_addr(input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y);
		int unsigned a;
		a = int'(x) * GRID_SIDE + int'(y);
		return a[ADDR_W-1:0];
	endfunction

	// True when a coordinate pair falls on the grid.
	function automatic logic in_grid(input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y);
		return (int'(x) < GRID_SIDE) && (int'(y) < GRID_SIDE);
	endfunction

endpackage

`default_nettype wire

/* hdl/cbms_if.sv */
// Handshake channels of the complex bin mean/deviation block.
// Depends on cbms_pkg for field widths.
`default_nettype none

// Request channel: one accumulate or read item.
interface cbms_req_if;
	logic                                valid;
	logic                                ready;
	logic                                op;
	logic [cbms_pkg::COORD_W-1:0]        bin_x;
	logic [cbms_pkg::COORD_W-1:0]        bin_y;
	logic signed [cbms_pkg::SAMPLE_W-1:0] sample_real;
	logic signed [cbms_pkg::SAMPLE_W-1:0] sample_imag;

	modport source(output valid, op, bin_x, bin_y, sample_real, sample_imag, input ready);
	modport sink(input valid, op, bin_x, bin_y, sample_real, sample_imag, output ready);
endinterface

// Response channel: statistics of one bin.
interface cbms_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [cbms_pkg::COORD_W-1:0]        out_x;
	logic [cbms_pkg::COORD_W-1:0]        out_y;
	logic signed [cbms_pkg::SAMPLE_W-1:0] mean_real;
	logic signed [cbms_pkg::SAMPLE_W-1:0] mean_imag;
	logic [cbms_pkg::SAMPLE_W-1:0]       std_dev;
	logic                                negative_variance;

	modport source(output valid, out_x, out_y, mean_real, mean_imag, std_dev,
		negative_variance, input ready);
	modport sink(input valid, out_x, out_y, mean_real, mean_imag, std_dev,
		negative_variance, output ready);
endinterface

`default_nettype wire

/* hdl/complex_bin_mean_stddev.sv */
// Top level of the complex bin mean/deviation block: configuration registers,
// front end and back end. Depends on cbms_pkg, cbms_if, cbms_front and cbms_back.
//
// The block keeps real, imaginary and squared-magnitude sums for each bin of a
// 16 x 16 grid. An accumulate item in the back end reads the bin store, then
// writes the updated sums; the front end squares the sample and queues up to two
// items, so it keeps taking items while the back end works until its queue is
// full. A read item in the back end runs three bit-serial divisions of 56 steps
// each by the frame count, a 28-step floor square root and the sequencing around
// them; the result then waits in an output register until taken. Bins read as
// zero from reset on through per-bin valid bits, so no clearing pass follows
// reset. Write the configuration only while the block is idle.
`default_nettype none

module complex_bin_mean_stddev (
	input  wire                                clk,
	input  wire                                arst_n,
	cbms_req_if.sink                           req,
	cbms_rsp_if.source                         rsp,
	input  wire                                cfg_we,
	input  wire [cbms_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [cbms_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	logic [cbms_pkg::CNT_W-1:0] frame_count_q;
	logic [cbms_pkg::TOL_W-1:0] var_tol_q;
	logic                       work_valid;
	logic                       work_ready;
	cbms_pkg::work_t            work;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= cbms_pkg::FRAME_COUNT_RST;
			var_tol_q     <= cbms_pkg::VAR_TOL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				cbms_pkg::REG_FRAME_COUNT: frame_count_q <= cfg_wdata[cbms_pkg::CNT_W-1:0];
				cbms_pkg::REG_VAR_TOL:     var_tol_q     <= cfg_wdata[cbms_pkg::TOL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front end with its work queue.
	cbms_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.work_valid(work_valid),
		.work_ready(work_ready),
		.work      (work)
	);

	// Back end with the bin store and the read-out units.
	cbms_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.work_valid (work_valid),
		.work_ready (work_ready),
		.work       (work),
		.frame_count(frame_count_q),
		.var_tol    (var_tol_q),
		.rsp        (rsp)
	);

endmodule

`default_nettype wire

/* hdl/cbms_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module cbms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* hdl/cbms_front.sv */
// Front end: accepts items, squares the sample and queues work for the back end.
// Depends on cbms_pkg and cbms_if.
`default_nettype none

module cbms_front (
	input  wire                  clk,
	input  wire                  arst_n,
	cbms_req_if.sink             req,
	output logic                 work_valid,
	input  wire                  work_ready,
	output cbms_pkg::work_t      work
);

	logic                                valid_s1;
	logic                                op_s1;
	logic [cbms_pkg::COORD_W-1:0]        x_s1;
	logic [cbms_pkg::COORD_W-1:0]        y_s1;
	logic signed [cbms_pkg::SAMPLE_W-1:0] re_s1;
	logic signed [cbms_pkg::SAMPLE_W-1:0] im_s1;

	logic signed [cbms_pkg::SQ_W-1:0]    sq_re;
	logic signed [cbms_pkg::SQ_W-1:0]    sq_im;
	cbms_pkg::work_t                     push_item;

	cbms_pkg::work_t fifo_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            full;
	logic            push;
	logic            pop;

	assign full = (count_q == 2'd2);
	assign push = valid_s1 && !full;
	assign pop  = work_valid && work_ready;
	assign req.ready = !valid_s1 || !full;

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			op_s1 <= req.op;
			x_s1  <= req.bin_x;
			y_s1  <= req.bin_y;
			re_s1 <= req.sample_real;
			im_s1 <= req.sample_imag;
		end
	end

	// Squared magnitude of the sample; the queue registers the product.
	always_comb begin
		sq_re = re_s1 * re_s1;
		sq_im = im_s1 * im_s1;
		push_item.op    = op_s1;
		push_item.bin_x = x_s1;
		push_item.bin_y = y_s1;
		push_item.re    = re_s1;
		push_item.im    = im_s1;
		push_item.pwr   = {1'b0, sq_re} + {1'b0, sq_im};
	end

	// Two-entry queue between front and back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_item;
		end
	end

	assign work_valid = (count_q != 2'd0);
	assign work       = fifo_q[rd_ptr_q];

endmodule

`default_nettype wire

/* hdl/cbms_div.sv */
// Bit-serial restoring divider: wide dividend by an 8-bit divisor, one bit a cycle.
// Depends on cbms_pkg.
`default_nettype none

module cbms_div (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire [cbms_pkg::DIV_W-1:0]        dividend,
	input  wire [cbms_pkg::CNT_W-1:0]        divisor,
	output cbms_pkg::unit_stat_t             stat,
	output logic [cbms_pkg::DIV_W-1:0]       quotient
);

	localparam logic [cbms_pkg::DIV_CNT_W-1:0] DIV_LAST =
		cbms_pkg::DIV_CNT_W'(cbms_pkg::DIV_W - 1);

	logic [cbms_pkg::DIV_W-1:0]     quo_q;
	logic [cbms_pkg::CNT_W-1:0]     rem_q;
	logic [cbms_pkg::CNT_W-1:0]     dvs_q;
	logic [cbms_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;

	logic [cbms_pkg::CNT_W:0]       trial;
	logic [cbms_pkg::CNT_W:0]       diff;
	logic                           ge;

	// One restoring step.
	always_comb begin
		trial = {rem_q, quo_q[cbms_pkg::DIV_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_LAST;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[cbms_pkg::DIV_W-2:0], ge};
			rem_q <= ge ? diff[cbms_pkg::CNT_W-1:0] : trial[cbms_pkg::CNT_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

`default_nettype wire

/* hdl/cbms_sqrt.sv */
// Digit-by-digit floor square root, one result bit a cycle.
// Depends on cbms_pkg.
`default_nettype none

module cbms_sqrt (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire [cbms_pkg::POWER_W-1:0]      radicand,
	output cbms_pkg::unit_stat_t             stat,
	output logic [cbms_pkg::ROOT_W-1:0]      root
);

	localparam int REM_W = cbms_pkg::ROOT_W + 3;
	localparam logic [cbms_pkg::ROOT_CNT_W-1:0] ROOT_LAST =
		cbms_pkg::ROOT_CNT_W'(cbms_pkg::ROOT_W - 1);

	logic [cbms_pkg::POWER_W-1:0]    rad_q;
	logic [REM_W-1:0]                rem_q;
	logic [cbms_pkg::ROOT_W-1:0]     root_q;
	logic [cbms_pkg::ROOT_CNT_W-1:0] cnt_q;
	logic                            busy_q;
	logic                            done_q;

	logic [REM_W-1:0]                shifted;
	logic [REM_W-1:0]                trial;
	logic                            ge;

	// Bring down two radicand bits and try the next root bit.
	always_comb begin
		shifted = {rem_q[REM_W-3:0], rad_q[cbms_pkg::POWER_W-1 -: 2]};
		trial   = REM_W'({root_q, 2'b01});
		ge      = (shifted >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ROOT_LAST;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[cbms_pkg::POWER_W-3:0], 2'b00};
			rem_q  <= ge ? (shifted - trial) : shifted;
			root_q <= {root_q[cbms_pkg::ROOT_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign root      = root_q;

endmodule

`default_nettype wire

/* hdl/cbms_back.sv */
// Back end: bin store read-modify-write, read-out sequencer and result register.
// Depends on cbms_pkg, cbms_if, cbms_ram, cbms_div and cbms_sqrt.
`default_nettype none

module cbms_back (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          work_valid,
	output logic                         work_ready,
	input  cbms_pkg::work_t              work,
	input  wire [cbms_pkg::CNT_W-1:0]    frame_count,
	input  wire [cbms_pkg::TOL_W-1:0]    var_tol,
	cbms_rsp_if.source                   rsp
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ACC   = 4'd1;
	localparam logic [3:0] S_LOAD  = 4'd2;
	localparam logic [3:0] S_DIV_R = 4'd3;
	localparam logic [3:0] S_DIV_I = 4'd4;
	localparam logic [3:0] S_DIV_P = 4'd5;
	localparam logic [3:0] S_MAG   = 4'd6;
	localparam logic [3:0] S_VAR   = 4'd7;
	localparam logic [3:0] S_ROOT  = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;

	localparam logic [cbms_pkg::SUM_W-1:0] MEAN_MAX =
		cbms_pkg::SUM_W'((64'd1 << (cbms_pkg::SAMPLE_W - 1)) - 64'd1);

	logic [3:0]                           state_q;
	cbms_pkg::work_t                      item_q;
	logic [cbms_pkg::ADDR_W-1:0]          addr_q;
	logic [cbms_pkg::BIN_COUNT-1:0]       valid_bits_q;

	logic                                 neg_r_q;
	logic                                 neg_i_q;
	logic [cbms_pkg::SUM_W-1:0]           dvd_i_q;
	logic [cbms_pkg::POWER_W-1:0]         sp_q;
	logic signed [cbms_pkg::SAMPLE_W-1:0] mean_r_q;
	logic signed [cbms_pkg::SAMPLE_W-1:0] mean_i_q;
	logic [cbms_pkg::POWER_W-1:0]         mp_q;
	logic [cbms_pkg::SQ_W-1:0]            sqr_q;
	logic [cbms_pkg::SQ_W-1:0]            sqi_q;
	logic                                 flag_q;
	logic [cbms_pkg::SAMPLE_W-1:0]        sd_q;

	logic                                 out_valid_q;
	logic [cbms_pkg::COORD_W-1:0]         out_x_q;
	logic [cbms_pkg::COORD_W-1:0]         out_y_q;
	logic signed [cbms_pkg::SAMPLE_W-1:0] out_mr_q;
	logic signed [cbms_pkg::SAMPLE_W-1:0] out_mi_q;
	logic [cbms_pkg::SAMPLE_W-1:0]        out_sd_q;
	logic                                 out_flag_q;

	logic                                 pop;
	logic [cbms_pkg::ADDR_W-1:0]          rd_addr;
	logic                                 ram_we;
	cbms_pkg::sums_t                      ram_rdata;
	cbms_pkg::sums_t                      cur;
	cbms_pkg::sums_t                      acc_sum;
	logic [cbms_pkg::SUM_W-1:0]           mag_r;
	logic [cbms_pkg::SUM_W-1:0]           mag_i;

	logic                                 div_start;
	logic [cbms_pkg::DIV_W-1:0]           div_dvd;
	logic [cbms_pkg::CNT_W-1:0]           divisor;
	cbms_pkg::unit_stat_t                 div_stat;
	logic [cbms_pkg::DIV_W-1:0]           div_quo;

	logic                                 root_start;
	cbms_pkg::unit_stat_t                 root_stat;
	logic [cbms_pkg::ROOT_W-1:0]          root;

	logic signed [cbms_pkg::SQ_W-1:0]     prod_r;
	logic signed [cbms_pkg::SQ_W-1:0]     prod_i;
	logic [cbms_pkg::POWER_W-1:0]         mag_sum;
	logic                                 no_deficit;
	logic [cbms_pkg::POWER_W-1:0]         variance;
	logic                                 load_out;

	// Truncated quotient magnitude with sign, saturated to the sample range.
	function automatic logic [cbms_pkg::SAMPLE_W-1:0] sat_mean(
		input logic [cbms_pkg::SUM_W-1:0] q, input logic neg);
		logic [cbms_pkg::SUM_W-1:0] nq;
		logic [cbms_pkg::SAMPLE_W-1:0] r;
		nq = ~q + 1'b1;
		if (!neg) begin
			r = (q > MEAN_MAX) ? MEAN_MAX[cbms_pkg::SAMPLE_W-1:0] : q[cbms_pkg::SAMPLE_W-1:0];
		end else if (q > MEAN_MAX + 1'b1) begin
			r = {1'b1, {(cbms_pkg::SAMPLE_W-1){1'b0}}};
		end else begin
			r = nq[cbms_pkg::SAMPLE_W-1:0];
		end
		return r;
	endfunction

	assign work_ready = (state_q == S_IDLE);
	assign pop        = work_valid && work_ready;
	assign rd_addr    = cbms_pkg::bin_addr(work.bin_x, work.bin_y);
	assign divisor    = (frame_count == '0) ? cbms_pkg::CNT_W'(1) : frame_count;
	assign load_out   = (state_q == S_OUT) && (!out_valid_q || rsp.ready);

	// Bin store: sums of all three terms in one word.
	cbms_ram #(
		.WIDTH(cbms_pkg::ENTRY_W),
		.DEPTH(cbms_pkg::BIN_COUNT)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_q),
		.wdata(acc_sum),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// An entry that was never written or was cleared reads as zero.
	always_comb begin
		cur = valid_bits_q[addr_q] ? ram_rdata : '0;
		acc_sum.sr = cur.sr + {{(cbms_pkg::SUM_W-cbms_pkg::SAMPLE_W){item_q.re[cbms_pkg::SAMPLE_W-1]}},
			item_q.re};
		acc_sum.si = cur.si + {{(cbms_pkg::SUM_W-cbms_pkg::SAMPLE_W){item_q.im[cbms_pkg::SAMPLE_W-1]}},
			item_q.im};
		acc_sum.sp = cur.sp + cbms_pkg::POWER_W'(item_q.pwr);
		mag_r = cur.sr[cbms_pkg::SUM_W-1] ? (~cur.sr + 1'b1) : cur.sr;
		mag_i = cur.si[cbms_pkg::SUM_W-1] ? (~cur.si + 1'b1) : cur.si;
		ram_we = (state_q == S_ACC);
	end

	// Divider operand sequencing: real, imaginary, then power.
	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		case (state_q)
			S_LOAD: begin
				div_start = 1'b1;
				div_dvd   = cbms_pkg::DIV_W'(mag_r);
			end
			S_DIV_R: begin
				div_start = div_stat.done;
				div_dvd   = cbms_pkg::DIV_W'(dvd_i_q);
			end
			S_DIV_I: begin
				div_start = div_stat.done;
				div_dvd   = sp_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	cbms_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dvd),
		.divisor (divisor),
		.stat    (div_stat),
		.quotient(div_quo)
	);

	// Squared mean magnitude and variance.
	always_comb begin
		prod_r     = mean_r_q * mean_r_q;
		prod_i     = mean_i_q * mean_i_q;
		mag_sum    = cbms_pkg::POWER_W'({1'b0, sqr_q} + {1'b0, sqi_q});
		no_deficit = (mp_q >= mag_sum);
		variance   = no_deficit ? (mp_q - mag_sum) : '0;
		root_start = (state_q == S_VAR);
	end

	cbms_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (root_start),
		.radicand(variance),
		.stat    (root_stat),
		.root    (root)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_bits_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (cbms_pkg::in_grid(work.bin_x, work.bin_y)) begin
							state_q <= (work.op == cbms_pkg::OP_READ) ? S_LOAD : S_ACC;
						end else begin
							state_q <= (work.op == cbms_pkg::OP_READ) ? S_OUT : S_IDLE;
						end
					end
				end
				S_ACC: begin
					valid_bits_q[addr_q] <= 1'b1;
					state_q <= S_IDLE;
				end
				S_LOAD: begin
					valid_bits_q[addr_q] <= 1'b0;
					state_q <= S_DIV_R;
				end
				S_DIV_R: begin
					if (div_stat.done) begin
						state_q <= S_DIV_I;
					end
				end
				S_DIV_I: begin
					if (div_stat.done) begin
						state_q <= S_DIV_P;
					end
				end
				S_DIV_P: begin
					if (div_stat.done) begin
						state_q <= S_MAG;
					end
				end
				S_MAG: begin
					state_q <= S_VAR;
				end
				S_VAR: begin
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (root_stat.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		if (pop) begin
			item_q   <= work;
			addr_q   <= rd_addr;
			mean_r_q <= '0;
			mean_i_q <= '0;
			sd_q     <= '0;
			flag_q   <= 1'b0;
		end
		if (state_q == S_LOAD) begin
			neg_r_q <= cur.sr[cbms_pkg::SUM_W-1];
			neg_i_q <= cur.si[cbms_pkg::SUM_W-1];
			dvd_i_q <= mag_i;
			sp_q    <= cur.sp;
		end
		if (state_q == S_DIV_R && div_stat.done) begin
			mean_r_q <= sat_mean(div_quo[cbms_pkg::SUM_W-1:0], neg_r_q);
		end
		if (state_q == S_DIV_I && div_stat.done) begin
			mean_i_q <= sat_mean(div_quo[cbms_pkg::SUM_W-1:0], neg_i_q);
		end
		if (state_q == S_DIV_P && div_stat.done) begin
			mp_q <= div_quo;
		end
		if (state_q == S_MAG) begin
			sqr_q <= prod_r;
			sqi_q <= prod_i;
		end
		if (state_q == S_VAR) begin
			flag_q <= !no_deficit &&
				((mag_sum - mp_q) > cbms_pkg::POWER_W'(var_tol));
		end
		if (state_q == S_ROOT && root_stat.done) begin
			sd_q <= (root[cbms_pkg::ROOT_W-1:cbms_pkg::SAMPLE_W] != '0) ? '1 :
				root[cbms_pkg::SAMPLE_W-1:0];
		end
	end

	// Result register; it holds one item until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_x_q    <= item_q.bin_x;
			out_y_q    <= item_q.bin_y;
			out_mr_q   <= mean_r_q;
			out_mi_q   <= mean_i_q;
			out_sd_q   <= sd_q;
			out_flag_q <= flag_q;
		end
	end

	assign rsp.valid             = out_valid_q;
	assign rsp.out_x             = out_x_q;
	assign rsp.out_y             = out_y_q;
	assign rsp.mean_real         = out_mr_q;
	assign rsp.mean_imag         = out_mi_q;
	assign rsp.std_dev           = out_sd_q;
	assign rsp.negative_variance = out_flag_q;

	// A new result only appears after the sequencer reached its output step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result raised outside the output step");

	// A read leaves its bin cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD |=> !valid_bits_q[$past(addr_q)])
		else $error("bin not cleared after read");

	// The divider finishes only while a division is awaited.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_DIV_R || state_q == S_DIV_I || state_q == S_DIV_P))
		else $error("divider finished outside a division step");

	// The root unit finishes only while the root is awaited.
	assert property (@(posedge clk) disable iff (!arst_n)
		root_stat.done |-> state_q == S_ROOT)
		else $error("root unit finished outside the root step");

endmodule

`default_nettype wire
